// File: rtl/core/text_console_writer_defines.svh
// Assertion macros for the text console writer checker.
// No dependencies; include with the bare file name.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// Shared constants for the text console writer: request codes, geometry
// defaults and stream widths. No dependencies.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RST     = 8'd15;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

endpackage

// File: rtl/core/text_console_writer.sv
// Text console writer: top level with the cell store, cursor and sequencer.
// Depends on tcw_pkg.
//
// Usage
//   in_*  : one request per item (put char, read cell, set cursor, clear).
//   out_* : exactly one result per request, in request order.
//   cfg_* : default_attribute; the user writes only while idle, unchecked.
// Sequencing (C = COLUMNS*ROWS)
//   put without scroll, set cursor : result loaded in the execute step
//   read cell                       : execute, then registered store read
//   clear                           : C cells, one cell written per cycle
//   put that scrolls                : each row moves up; the single store
//                                     write port moves one cell per cycle
//   One request is in flight at a time; in_tready is low while it works.
// Reset
//   After rst_n the store is swept to zero, one cell per cycle, all C cells,
//   before the first request is taken. Cursor goes to the top left cell,
//   default_attribute to 15.
// Stall
//   The result sits in an output register; if out_tready is low the
//   sequencer holds in its last step until the register frees up.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: use_cursor[0], col[7:1], row[12:8], char_code[20:13],
  //        attribute[28:21], zero pad [31:29]
  input  logic [tcw_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: req_type[1:0]
  input  logic [tcw_pkg::IN_TUSER_W-1:0] in_tuser,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
  //        cursor_row[27:23], scrolled[28], zero pad [31:29]
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // default_attribute write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RDATA = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // request fields
  logic       f_use;
  logic [6:0] f_col;
  logic [4:0] f_row;
  logic [7:0] f_char;
  logic [7:0] f_attr;
  logic [1:0] f_req;

  assign f_use  = in_tdata[0];
  assign f_col  = in_tdata[7:1];
  assign f_row  = in_tdata[12:8];
  assign f_char = in_tdata[20:13];
  assign f_attr = in_tdata[28:21];
  assign f_req  = in_tuser[1:0];

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [7:0]    dflt_attr_r;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          rd_on_r, rd_on_nxt;
  logic          pend_r, pend_nxt;
  logic          init_r, init_nxt;
  logic          scr_r, scr_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic          out_valid_r;

  // latched request
  logic [1:0]    req_r, req_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [CW-1:0] pcol_r, pcol_nxt;
  logic [RW-1:0] prow_r, prow_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  // result payload
  logic [7:0] o_char_r, o_attr_r;
  logic [6:0] o_col_r;
  logic [4:0] o_row_r;
  logic       o_scr_r;

  // cell store: attribute in the high byte, character in the low byte
  logic [15:0]   cell_mem [CELLS];
  logic [15:0]   rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  // accept position: saturate col/row, or the cursor for use_cursor puts
  logic [CW-1:0] col_sat, pcol_in;
  logic [RW-1:0] row_sat, prow_in;
  logic          at_cursor;

  assign col_sat   = (int'(f_col) >= COLUMNS) ? LAST_COL : CW'(f_col);
  assign row_sat   = (int'(f_row) >= ROWS) ? LAST_ROW : RW'(f_row);
  assign at_cursor = f_use && (f_req == REQ_PUT);
  assign pcol_in   = at_cursor ? cur_col_r : col_sat;
  assign prow_in   = at_cursor ? cur_row_r : row_sat;

  // put step: newline or last column goes to the next row; last row wraps
  logic is_nl, row_end, wrap;
  assign is_nl   = (char_r == NEWLINE_CODE);
  assign row_end = is_nl || (pcol_r == LAST_COL);
  assign wrap    = row_end && (prow_r == LAST_ROW);

  logic       out_free, out_load;
  logic [7:0] ld_char, ld_attr;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt   = state_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    rd_on_nxt   = rd_on_r;
    pend_nxt    = pend_r;
    init_nxt    = init_r;
    scr_nxt     = scr_r;
    fill_nxt    = fill_r;
    req_nxt     = req_r;
    char_nxt    = char_r;
    attr_nxt    = attr_r;
    pcol_nxt    = pcol_r;
    prow_nxt    = prow_r;
    addr_nxt    = addr_r;
    mem_we      = 1'b0;
    mem_waddr   = dst_r;
    mem_wdata   = fill_r;
    mem_re      = 1'b0;
    mem_raddr   = addr_r;
    out_load    = 1'b0;
    ld_char     = 8'd0;
    ld_attr     = 8'd0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = f_req;
          char_nxt  = f_char;
          attr_nxt  = (f_attr == 8'd0) ? dflt_attr_r : f_attr;
          pcol_nxt  = pcol_in;
          prow_nxt  = prow_in;
          addr_nxt  = AW'(prow_in) * COLS_A + AW'(pcol_in);
          scr_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_r)
          REQ_PUT: begin
            // write is repeated harmlessly while the result waits
            mem_we    = !is_nl;
            mem_waddr = addr_r;
            mem_wdata = {attr_r, char_r};
            if (wrap) begin
              cur_col_nxt = '0;
              cur_row_nxt = LAST_ROW;
              scr_nxt     = 1'b1;
              src_nxt     = COLS_A;
              dst_nxt     = '0;
              rd_on_nxt   = 1'b1;
              pend_nxt    = 1'b0;
              state_nxt   = ST_COPY;
            end else begin
              cur_col_nxt = row_end ? '0 : pcol_r + 1'b1;
              cur_row_nxt = row_end ? prow_r + 1'b1 : prow_r;
              if (out_free) begin
                out_load  = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          end
          REQ_READ: begin
            mem_re    = 1'b1;
            mem_raddr = addr_r;
            state_nxt = ST_RDATA;
          end
          REQ_SET: begin
            cur_col_nxt = pcol_r;
            cur_row_nxt = prow_r;
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            dst_nxt     = '0;
            fill_nxt    = {dflt_attr_r, SPACE_CODE};
            init_nxt    = 1'b0;
            state_nxt   = ST_FILL;
          end
        endcase
      end
      ST_RDATA: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_char   = rdata_r[7:0];
          ld_attr   = rdata_r[15:8];
          state_nxt = ST_IDLE;
        end
      end
      ST_COPY: begin
        // read row r+1 cells, write each one a row lower from rdata_r
        if (rd_on_r) begin
          mem_re    = 1'b1;
          mem_raddr = src_r;
          if (src_r == LAST_A) begin
            rd_on_nxt = 1'b0;
          end else begin
            src_nxt = src_r + 1'b1;
          end
        end
        pend_nxt = rd_on_r;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = rdata_r;
          dst_nxt   = dst_r + 1'b1;
        end
        if (!rd_on_r && !pend_r) begin
          fill_nxt  = '0;
          init_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = fill_r;
        if (dst_r == LAST_A) begin
          state_nxt = init_r ? ST_IDLE : ST_OUT;
          init_nxt  = 1'b0;
        end else begin
          dst_nxt = dst_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      dflt_attr_r <= ATTR_RST;
      src_r       <= '0;
      dst_r       <= '0;
      rd_on_r     <= 1'b0;
      pend_r      <= 1'b0;
      init_r      <= 1'b1;
      scr_r       <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      rd_on_r   <= rd_on_nxt;
      pend_r    <= pend_nxt;
      init_r    <= init_nxt;
      scr_r     <= scr_nxt;
      fill_r    <= fill_nxt;
      if (cfg_valid) begin
        dflt_attr_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    char_r <= char_nxt;
    attr_r <= attr_nxt;
    pcol_r <= pcol_nxt;
    prow_r <= prow_nxt;
    addr_r <= addr_nxt;
    if (out_load) begin
      o_char_r <= ld_char;
      o_attr_r <= ld_attr;
      o_col_r  <= 7'(cur_col_nxt);
      o_row_r  <= 5'(cur_row_nxt);
      o_scr_r  <= scr_nxt;
    end
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cell_mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_scr_r, o_row_r, o_col_r, o_attr_r, o_char_r};

endmodule

// File: rtl/core/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_defines.svh.
`include "text_console_writer_defines.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcw_pkg::*;

  logic       in_fire, out_stall, res_scr;
  logic [6:0] res_col;
  logic [4:0] res_row;

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign res_col   = out_tdata[22:16];
  assign res_row   = out_tdata[27:23];
  assign res_scr   = out_tdata[28];

  // one request in flight: no accept right after an accept
  `TCW_ASSERT_NEXT(a_one_in_flight, in_fire, !in_tready, "request taken while busy")

  // stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata),
    "stalled result changed")

  // reported cursor lies on the screen
  `TCW_ASSERT_NOW(a_cursor_range, out_tvalid,
    (int'(res_col) < COLUMNS) && (int'(res_row) < ROWS), "cursor off screen")

  // a scroll leaves the cursor at the start of the last row
  `TCW_ASSERT_NOW(a_scroll_home, out_tvalid && res_scr,
    (res_col == 7'd0) && (res_row == 5'(ROWS - 1)), "cursor wrong after scroll")

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);
